// File: src/csp_pkg.sv
// Shared constants and types for the circle versus segment penetration core.
// No dependencies; used by circle_segment_penetration_core.
package csp_pkg;

   localparam int COORD_WIDTH = 24;
   // Extra fraction bits kept on the distance from the square root.
   localparam int SQRT_GUARD  = 16;

   // Where the closest point lies along the segment.
   typedef enum logic [2:0] {
      PSEL_ZERO = 3'b001,
      PSEL_FULL = 3'b010,
      PSEL_PROJ = 3'b100
   } psel_type;

endpackage

// File: src/circle_segment_penetration_core.sv
// Circle versus line segment penetration: closest point, hit flag and push vector.
// Depends on csp_pkg for the default coordinate width, guard bits and select codes.
//
// Usage:
//   Each req_ beat carries one circle (centre, radius) and one segment (two endpoints).
//   Each rsp_ beat returns hit, the saturated push vector and the degenerate flag for
//   one request, in request order. Both channels use valid and ready.
//   Throughput is one request per cycle while the output does not stall. A request passes through
//   15 + (COORD_WIDTH + 1) + (COORD_WIDTH + 15) + COORD_WIDTH register stages, 103 at the
//   default width. Most of them lie in three bit-per-stage units in series: the projection
//   divider, the distance square root and the push divider.
//   Reset clears all valid bits; payload stages are not reset. When the receiver holds
//   rsp_ready low while a response waits, the whole pipeline freezes in place and
//   req_ready drops; while the output holds no beat the pipeline keeps advancing
//   whatever rsp_ready is, so no beat is lost or repeated.
module circle_segment_penetration_core #(
   parameter int COORD_WIDTH = csp_pkg::COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_circle_x,
   input  logic signed [COORD_WIDTH-1:0] req_circle_y,
   input  logic        [COORD_WIDTH-2:0] req_radius,
   input  logic signed [COORD_WIDTH-1:0] req_seg_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_seg_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_seg_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_seg_end_y,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic signed [COORD_WIDTH-1:0] rsp_push_x,
   output logic signed [COORD_WIDTH-1:0] rsp_push_y,
   output logic                          rsp_degenerate
);

   localparam int C   = COORD_WIDTH;
   localparam int G   = csp_pkg::SQRT_GUARD;
   localparam int HW  = C + 1;
   localparam int MW  = C + 1;
   localparam int PW  = 2 * MW;
   localparam int DW  = PW + 1;
   localparam int LO  = MW;
   localparam int HI  = DW - LO;
   localparam int NW  = DW + MW + 2;
   localparam int QB  = C + 1;
   localparam int VW  = C + 2;
   localparam int RW  = C - 1;
   localparam int D2W = 2 * VW + 1;
   localparam int SB  = RW + G;
   localparam int SW  = 2 * SB + 1;
   localparam int DLO = (SB + 1) / 2;
   localparam int DHI = SB - DLO;
   localparam int NW2 = VW + SB + 2;
   localparam int QB2 = C;
   localparam int T   = 15 + QB + SB + QB2;

   typedef struct packed {
      logic signed [HW-1:0] hx;
      logic signed [HW-1:0] hy;
      logic signed [HW-1:0] lx;
      logic signed [HW-1:0] ly;
      logic [RW-1:0]        r;
   } geo_type;

   typedef struct packed {
      logic [NW-1:0]      rem_x;
      logic [NW-1:0]      rem_y;
      logic [QB-1:0]      q_x;
      logic [QB-1:0]      q_y;
      logic [DW:0]        den;
      csp_pkg::psel_type  psel;
      geo_type            geo;
   } pj_type;

   typedef struct packed {
      logic [SW-1:0] rem;
      logic [SB-1:0] res;
      logic [VW-1:0] mx;
      logic [VW-1:0] my;
      logic          nx;
      logic          ny;
      logic          hit;
      logic          zero;
      logic [RW-1:0] r;
   } sq_type;

   typedef struct packed {
      logic [NW2-1:0] rem_x;
      logic [NW2-1:0] rem_y;
      logic [QB2-1:0] q_x;
      logic [QB2-1:0] q_y;
      logic [SB:0]    den;
      logic           ovf_x;
      logic           ovf_y;
      logic           nx;
      logic           ny;
      logic           hit;
      logic           zero;
   } pd_type;

   function automatic logic [MW-1:0] mag_h(logic signed [HW-1:0] v);
      return v[HW-1] ? MW'(-v) : MW'(v);
   endfunction

   function automatic logic [VW-1:0] mag_v(logic signed [VW-1:0] v);
      return v[VW-1] ? VW'(-v) : VW'(v);
   endfunction

   logic en;
   logic [T-1:0] val_ff, val_in;

   assign en        = !val_ff[T-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = val_ff[T-1];
   assign val_in    = {val_ff[T-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
      end else if (en) begin
         val_ff <= val_in;
      end
   end

   // Stage 1: offsets from the first endpoint.
   geo_type s1_geo_ff, s1_geo_in;

   always_comb begin
      s1_geo_in.hx = HW'(req_circle_x) - HW'(req_seg_start_x);
      s1_geo_in.hy = HW'(req_circle_y) - HW'(req_seg_start_y);
      s1_geo_in.lx = HW'(req_seg_end_x) - HW'(req_seg_start_x);
      s1_geo_in.ly = HW'(req_seg_end_y) - HW'(req_seg_start_y);
      s1_geo_in.r  = req_radius;
   end

   // Stage 2: magnitude products for the dot product and squared length.
   geo_type       s2_geo_ff;
   logic [PW-1:0] s2_t1_ff, s2_t2_ff, s2_qx_ff, s2_qy_ff;
   logic [PW-1:0] s2_t1_in, s2_t2_in, s2_qx_in, s2_qy_in;
   logic [MW-1:0] s2_mlx_ff, s2_mly_ff, s2_mlx_in, s2_mly_in;
   logic          s2_n1_ff, s2_n2_ff;

   always_comb begin
      s2_mlx_in = mag_h(s1_geo_ff.lx);
      s2_mly_in = mag_h(s1_geo_ff.ly);
      s2_t1_in  = mag_h(s1_geo_ff.hx) * s2_mlx_in;
      s2_t2_in  = mag_h(s1_geo_ff.hy) * s2_mly_in;
      s2_qx_in  = s2_mlx_in * s2_mlx_in;
      s2_qy_in  = s2_mly_in * s2_mly_in;
   end

   // Stage 3: signed dot product as magnitude and sign, squared length.
   geo_type       s3_geo_ff;
   logic [DW-1:0] s3_dot_ff, s3_len2_ff, s3_dot_in;
   logic [MW-1:0] s3_mlx_ff, s3_mly_ff;
   logic          s3_pos_ff, s3_pos_in;

   always_comb begin
      if (s2_n1_ff == s2_n2_ff) begin
         s3_dot_in = DW'(s2_t1_ff) + DW'(s2_t2_ff);
         s3_pos_in = !s2_n1_ff;
      end else if (s2_t1_ff >= s2_t2_ff) begin
         s3_dot_in = DW'(s2_t1_ff - s2_t2_ff);
         s3_pos_in = !s2_n1_ff;
      end else begin
         s3_dot_in = DW'(s2_t2_ff - s2_t1_ff);
         s3_pos_in = !s2_n2_ff;
      end
   end

   // Stage 4: clamp decision and low partial products of dot * |l|.
   geo_type             s4_geo_ff;
   csp_pkg::psel_type   s4_psel_ff, s4_psel_in;
   logic [HI-1:0]       s4_dhi_ff;
   logic [LO+MW-1:0]    s4_plo_x_ff, s4_plo_y_ff;
   logic [DW-1:0]       s4_len2_ff;
   logic [MW-1:0]       s4_mlx_ff, s4_mly_ff;

   always_comb begin
      if (!s3_pos_ff || s3_dot_ff == '0) begin
         s4_psel_in = csp_pkg::PSEL_ZERO;
      end else if (s3_dot_ff >= s3_len2_ff) begin
         s4_psel_in = csp_pkg::PSEL_FULL;
      end else begin
         s4_psel_in = csp_pkg::PSEL_PROJ;
      end
   end

   // Stage 5: high partial products.
   geo_type             s5_geo_ff;
   csp_pkg::psel_type   s5_psel_ff;
   logic [HI+MW-1:0]    s5_phi_x_ff, s5_phi_y_ff;
   logic [LO+MW-1:0]    s5_plo_x_ff, s5_plo_y_ff;
   logic [DW-1:0]       s5_len2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_geo_ff   <= s1_geo_in;
         s2_geo_ff   <= s1_geo_ff;
         s2_t1_ff    <= s2_t1_in;
         s2_t2_ff    <= s2_t2_in;
         s2_qx_ff    <= s2_qx_in;
         s2_qy_ff    <= s2_qy_in;
         s2_mlx_ff   <= s2_mlx_in;
         s2_mly_ff   <= s2_mly_in;
         s2_n1_ff    <= s1_geo_ff.hx[HW-1] ^ s1_geo_ff.lx[HW-1];
         s2_n2_ff    <= s1_geo_ff.hy[HW-1] ^ s1_geo_ff.ly[HW-1];
         s3_geo_ff   <= s2_geo_ff;
         s3_dot_ff   <= s3_dot_in;
         s3_pos_ff   <= s3_pos_in;
         s3_len2_ff  <= DW'(s2_qx_ff) + DW'(s2_qy_ff);
         s3_mlx_ff   <= s2_mlx_ff;
         s3_mly_ff   <= s2_mly_ff;
         s4_geo_ff   <= s3_geo_ff;
         s4_psel_ff  <= s4_psel_in;
         s4_dhi_ff   <= s3_dot_ff[DW-1:LO];
         s4_plo_x_ff <= s3_dot_ff[LO-1:0] * s3_mlx_ff;
         s4_plo_y_ff <= s3_dot_ff[LO-1:0] * s3_mly_ff;
         s4_len2_ff  <= s3_len2_ff;
         s4_mlx_ff   <= s3_mlx_ff;
         s4_mly_ff   <= s3_mly_ff;
         s5_geo_ff   <= s4_geo_ff;
         s5_psel_ff  <= s4_psel_ff;
         s5_phi_x_ff <= s4_dhi_ff * s4_mlx_ff;
         s5_phi_y_ff <= s4_dhi_ff * s4_mly_ff;
         s5_plo_x_ff <= s4_plo_x_ff;
         s5_plo_y_ff <= s4_plo_y_ff;
         s5_len2_ff  <= s4_len2_ff;
      end
   end

   // Projection divider: round(|l| * dot / len2) as floor((2 |l| dot + len2) / (2 len2)),
   // one quotient bit per stage.
   pj_type pj_ff [QB+1];
   pj_type pj0_in;

   always_comb begin
      pj0_in.rem_x = (((NW'(s5_phi_x_ff) << LO) + NW'(s5_plo_x_ff)) << 1) + NW'(s5_len2_ff);
      pj0_in.rem_y = (((NW'(s5_phi_y_ff) << LO) + NW'(s5_plo_y_ff)) << 1) + NW'(s5_len2_ff);
      pj0_in.q_x   = '0;
      pj0_in.q_y   = '0;
      pj0_in.den   = {s5_len2_ff, 1'b0};
      pj0_in.psel  = s5_psel_ff;
      pj0_in.geo   = s5_geo_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pj_ff[0] <= pj0_in;
      end
   end

   for (genvar k = 1; k <= QB; k++) begin : g_pj
      localparam int SH = QB - k;
      pj_type        pj_in;
      logic [NW-1:0] cmp;

      always_comb begin
         pj_in = pj_ff[k-1];
         cmp   = NW'(pj_ff[k-1].den) << SH;
         if (pj_ff[k-1].rem_x >= cmp) begin
            pj_in.rem_x   = pj_ff[k-1].rem_x - cmp;
            pj_in.q_x[SH] = 1'b1;
         end
         if (pj_ff[k-1].rem_y >= cmp) begin
            pj_in.rem_y   = pj_ff[k-1].rem_y - cmp;
            pj_in.q_y[SH] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            pj_ff[k] <= pj_in;
         end
      end
   end

   // Offset from the closest point to the centre.
   pj_type                pj_last;
   logic signed [VW-1:0]  sv_px, sv_py;
   logic signed [VW-1:0]  sv_vx_ff, sv_vy_ff;
   logic [RW-1:0]         sv_r_ff;

   assign pj_last = pj_ff[QB];

   always_comb begin
      case (pj_last.psel)
         csp_pkg::PSEL_FULL: begin
            sv_px = VW'(pj_last.geo.lx);
            sv_py = VW'(pj_last.geo.ly);
         end
         csp_pkg::PSEL_PROJ: begin
            sv_px = pj_last.geo.lx[HW-1] ? -signed'(VW'(pj_last.q_x)) : signed'(VW'(pj_last.q_x));
            sv_py = pj_last.geo.ly[HW-1] ? -signed'(VW'(pj_last.q_y)) : signed'(VW'(pj_last.q_y));
         end
         default: begin
            sv_px = '0;
            sv_py = '0;
         end
      endcase
   end

   // Squares of the offset and of the radius.
   logic [VW-1:0]    m_mx_ff, m_my_ff, m_mx_in, m_my_in;
   logic             m_nx_ff, m_ny_ff;
   logic [2*VW-1:0]  m_sqx_ff, m_sqy_ff;
   logic [2*RW-1:0]  m_rr_ff;
   logic [RW-1:0]    m_r_ff;

   assign m_mx_in = mag_v(sv_vx_ff);
   assign m_my_in = mag_v(sv_vy_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         sv_vx_ff <= VW'(pj_last.geo.hx) - sv_px;
         sv_vy_ff <= VW'(pj_last.geo.hy) - sv_py;
         sv_r_ff  <= pj_last.geo.r;
         m_mx_ff  <= m_mx_in;
         m_my_ff  <= m_my_in;
         m_nx_ff  <= sv_vx_ff[VW-1];
         m_ny_ff  <= sv_vy_ff[VW-1];
         m_sqx_ff <= m_mx_in * m_mx_in;
         m_sqy_ff <= m_my_in * m_my_in;
         m_rr_ff  <= sv_r_ff * sv_r_ff;
         m_r_ff   <= sv_r_ff;
      end
   end

   // Square root of d2 * 2^(2G), one result bit per stage. On a hit d2 < r^2, so the
   // low bits of d2 hold it whole; other inputs give a value that is never used.
   sq_type         sq_ff [SB+1];
   sq_type         sq0_in;
   logic [D2W-1:0] sq_d2;

   always_comb begin
      sq_d2       = D2W'(m_sqx_ff) + D2W'(m_sqy_ff);
      sq0_in.rem  = SW'({sq_d2[2*RW-1:0], {(2*G){1'b0}}});
      sq0_in.res  = '0;
      sq0_in.mx   = m_mx_ff;
      sq0_in.my   = m_my_ff;
      sq0_in.nx   = m_nx_ff;
      sq0_in.ny   = m_ny_ff;
      sq0_in.hit  = sq_d2 < D2W'(m_rr_ff);
      sq0_in.zero = sq_d2 == '0;
      sq0_in.r    = m_r_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff[0] <= sq0_in;
      end
   end

   for (genvar k = 1; k <= SB; k++) begin : g_sq
      localparam int B = SB - k;
      sq_type        sq_in;
      logic [SW-1:0] trial;

      always_comb begin
         sq_in = sq_ff[k-1];
         trial = (SW'(sq_ff[k-1].res) << (B + 1)) | (SW'(1) << (2 * B));
         if (sq_ff[k-1].rem >= trial) begin
            sq_in.rem    = sq_ff[k-1].rem - trial;
            sq_in.res[B] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff[k] <= sq_in;
         end
      end
   end

   // Penetration depth and the product |v| * depth in two halves.
   sq_type            sq_last;
   logic [SB-1:0]     dp_depth_ff, dp_s_ff;
   logic [VW-1:0]     dp_mx_ff, dp_my_ff;
   logic              dp_nx_ff, dp_ny_ff, dp_hit_ff, dp_zero_ff;
   logic [VW+DLO-1:0] p1_plo_x_ff, p1_plo_y_ff;
   logic [DHI-1:0]    p1_dhi_ff;
   logic [VW-1:0]     p1_mx_ff, p1_my_ff;
   logic [SB-1:0]     p1_s_ff;
   logic              p1_nx_ff, p1_ny_ff, p1_hit_ff, p1_zero_ff;
   logic [VW+DHI-1:0] p2_phi_x_ff, p2_phi_y_ff;
   logic [VW+DLO-1:0] p2_plo_x_ff, p2_plo_y_ff;
   logic [SB-1:0]     p2_s_ff;
   logic              p2_nx_ff, p2_ny_ff, p2_hit_ff, p2_zero_ff;
   logic [NW2-1:0]    p3_num_x_ff, p3_num_y_ff;
   logic [SB-1:0]     p3_s_ff;
   logic              p3_nx_ff, p3_ny_ff, p3_hit_ff, p3_zero_ff;

   assign sq_last = sq_ff[SB];

   always_ff @(posedge clock) begin
      if (en) begin
         dp_depth_ff <= (SB'(sq_last.r) << G) - sq_last.res;
         dp_s_ff     <= sq_last.res;
         dp_mx_ff    <= sq_last.mx;
         dp_my_ff    <= sq_last.my;
         dp_nx_ff    <= sq_last.nx;
         dp_ny_ff    <= sq_last.ny;
         dp_hit_ff   <= sq_last.hit;
         dp_zero_ff  <= sq_last.zero;
         p1_plo_x_ff <= dp_mx_ff * dp_depth_ff[DLO-1:0];
         p1_plo_y_ff <= dp_my_ff * dp_depth_ff[DLO-1:0];
         p1_dhi_ff   <= dp_depth_ff[SB-1:DLO];
         p1_mx_ff    <= dp_mx_ff;
         p1_my_ff    <= dp_my_ff;
         p1_s_ff     <= dp_s_ff;
         p1_nx_ff    <= dp_nx_ff;
         p1_ny_ff    <= dp_ny_ff;
         p1_hit_ff   <= dp_hit_ff;
         p1_zero_ff  <= dp_zero_ff;
         p2_phi_x_ff <= p1_mx_ff * p1_dhi_ff;
         p2_phi_y_ff <= p1_my_ff * p1_dhi_ff;
         p2_plo_x_ff <= p1_plo_x_ff;
         p2_plo_y_ff <= p1_plo_y_ff;
         p2_s_ff     <= p1_s_ff;
         p2_nx_ff    <= p1_nx_ff;
         p2_ny_ff    <= p1_ny_ff;
         p2_hit_ff   <= p1_hit_ff;
         p2_zero_ff  <= p1_zero_ff;
         p3_num_x_ff <= (((NW2'(p2_phi_x_ff) << DLO) + NW2'(p2_plo_x_ff)) << 1)
                        + NW2'(p2_s_ff);
         p3_num_y_ff <= (((NW2'(p2_phi_y_ff) << DLO) + NW2'(p2_plo_y_ff)) << 1)
                        + NW2'(p2_s_ff);
         p3_s_ff     <= p2_s_ff;
         p3_nx_ff    <= p2_nx_ff;
         p3_ny_ff    <= p2_ny_ff;
         p3_hit_ff   <= p2_hit_ff;
         p3_zero_ff  <= p2_zero_ff;
      end
   end

   // Push divider. A quotient of 2^C or more saturates at once; below that it is
   // resolved one bit per stage.
   pd_type         pd_ff [QB2+1];
   pd_type         pd0_in;
   logic [NW2-1:0] pd_lim;

   always_comb begin
      pd_lim       = NW2'({p3_s_ff, 1'b0}) << QB2;
      pd0_in.rem_x = p3_num_x_ff;
      pd0_in.rem_y = p3_num_y_ff;
      pd0_in.q_x   = '0;
      pd0_in.q_y   = '0;
      pd0_in.den   = {p3_s_ff, 1'b0};
      pd0_in.ovf_x = p3_num_x_ff >= pd_lim;
      pd0_in.ovf_y = p3_num_y_ff >= pd_lim;
      pd0_in.nx    = p3_nx_ff;
      pd0_in.ny    = p3_ny_ff;
      pd0_in.hit   = p3_hit_ff;
      pd0_in.zero  = p3_zero_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pd_ff[0] <= pd0_in;
      end
   end

   for (genvar k = 1; k <= QB2; k++) begin : g_pd
      localparam int SH = QB2 - k;
      pd_type         pd_in;
      logic [NW2-1:0] cmp;

      always_comb begin
         pd_in = pd_ff[k-1];
         cmp   = NW2'(pd_ff[k-1].den) << SH;
         if (pd_ff[k-1].rem_x >= cmp) begin
            pd_in.rem_x   = pd_ff[k-1].rem_x - cmp;
            pd_in.q_x[SH] = 1'b1;
         end
         if (pd_ff[k-1].rem_y >= cmp) begin
            pd_in.rem_y   = pd_ff[k-1].rem_y - cmp;
            pd_in.q_y[SH] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            pd_ff[k] <= pd_in;
         end
      end
   end

   // Saturation, sign and the no-hit and centre-on-segment cases.
   pd_type               pd_last;
   logic [C-1:0]         out_mx, out_my;
   logic                 out_push_en;
   logic                 out_hit_ff, out_degen_ff;
   logic signed [C-1:0]  out_px_ff, out_py_ff;

   assign pd_last     = pd_ff[QB2];
   assign out_push_en = pd_last.hit && !pd_last.zero;

   always_comb begin
      if (pd_last.ovf_x || pd_last.q_x[C-1]) begin
         out_mx = pd_last.nx ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
      end else begin
         out_mx = pd_last.q_x;
      end
      if (pd_last.ovf_y || pd_last.q_y[C-1]) begin
         out_my = pd_last.ny ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
      end else begin
         out_my = pd_last.q_y;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_hit_ff   <= pd_last.hit;
         out_degen_ff <= pd_last.hit && pd_last.zero;
         out_px_ff    <= !out_push_en ? '0 : pd_last.nx ? -signed'(out_mx) : signed'(out_mx);
         out_py_ff    <= !out_push_en ? '0 : pd_last.ny ? -signed'(out_my) : signed'(out_my);
      end
   end

   assign rsp_hit        = out_hit_ff;
   assign rsp_push_x     = out_px_ff;
   assign rsp_push_y     = out_py_ff;
   assign rsp_degenerate = out_degen_ff;

endmodule
